### rtl/sum_of_cosines_force_unit_macros.svh
// Assertion macros for the sum of cosines force unit checker.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef SUM_OF_COSINES_FORCE_UNIT_MACROS_SVH
`define SUM_OF_COSINES_FORCE_UNIT_MACROS_SVH

// Property sampled at the rising clock edge, off during reset.
`define SCF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("scf assertion failed");

// Condition in one cycle implies another in the next cycle.
`define SCF_ASSERT_NEXT(lbl, cond, nxt) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error("scf assertion failed");

`endif

### rtl/scf_pkg.sv
// Package for the sum of cosines force unit: widths, register indexes,
// CORDIC constants and the result type of the CORDIC core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scf_pkg;

  localparam int TONES  = 3;
  localparam int TONE_W = (TONES > 1) ? $clog2(TONES) : 1;
  localparam int CNT_W  = 2;

  localparam int IN_W   = 32;
  localparam int OUT_W  = 18;
  localparam int TD_W   = ((OUT_W + 7) / 8) * 8;
  localparam int AMP_W  = 16;
  localparam int STEP_W = 32;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_TONE_COUNT = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_AMP_BASE   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_BASE  = 3'd4;

  // phase multiply: two tick bits per cycle, MSB first
  localparam int PH_DIGITS = IN_W / 2;
  localparam int PH_CNT_W  = $clog2(PH_DIGITS);

  localparam int CORDIC_ITERS = 16;
  localparam int ITER_W       = $clog2(CORDIC_ITERS);
  localparam int XY_W         = 33;
  localparam int Z_W          = 32;
  localparam int COS_W        = 17;
  localparam int Q15_W        = 16;
  localparam int PROD_W       = AMP_W + COS_W;

  localparam logic signed [XY_W-1:0] CORDIC_X0 = 33'sd652032874;

  typedef struct packed {
    logic                    done;
    logic signed [COS_W-1:0] cosine;
  } cos_res_t;

  function automatic logic signed [Z_W-1:0] atan_val(input logic [ITER_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      4'd0:    v = 32'sh20000000;
      4'd1:    v = 32'sh12E4051E;
      4'd2:    v = 32'sh09FB385B;
      4'd3:    v = 32'sh051111D4;
      4'd4:    v = 32'sh028B0D43;
      4'd5:    v = 32'sh0145D7E1;
      4'd6:    v = 32'sh00A2F61E;
      4'd7:    v = 32'sh00517C55;
      4'd8:    v = 32'sh0028BE53;
      4'd9:    v = 32'sh00145F2F;
      4'd10:   v = 32'sh000A2F98;
      4'd11:   v = 32'sh000517CC;
      4'd12:   v = 32'sh00028BE6;
      4'd13:   v = 32'sh000145F3;
      4'd14:   v = 32'sh0000A2FA;
      4'd15:   v = 32'sh0000517D;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/sum_of_cosines_force_unit.sv
// Top level of the sum of cosines force unit: config registers, serial phase
// multiply, tone sequencer, multiply-accumulate. Depends on scf_pkg, scf_cordic.
//
//   channel   dir  handshake                      payload
//   cfg       in   cfg_we_i                       cfg_addr_i, cfg_wdata_i
//   s_axis    in   s_axis_tvalid/s_axis_tready    time_tick
//   m_axis    out  m_axis_tvalid/m_axis_tready    force_sample
//
// The phase multiply takes two tick bits per cycle for all tones.
// The shared CORDIC takes 16 rotations plus rounding for each tone.
// One item in flight; a finished result waits in the output register while
// the next item is taken. Reset puts the control state in idle and clears the config to zero.
`timescale 1ns / 1ps
`default_nettype none

module sum_of_cosines_force_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [scf_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [scf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [scf_pkg::IN_W-1:0]        s_axis_tdata,  // [31:0] time_tick
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [scf_pkg::TD_W-1:0]             m_axis_tdata   // [17:0] force_sample
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PHASE  = 6'b000010,
    ST_LAUNCH = 6'b000100,
    ST_ROT    = 6'b001000,
    ST_ACC    = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  localparam logic signed [scf_pkg::PROD_W-1:0] RND_HALF = 33'sd16384;

  state_e                                 state_q, state_d;
  logic [scf_pkg::CNT_W-1:0]              tone_cnt_q, n_eff;
  logic signed [scf_pkg::AMP_W-1:0]       amp_q  [scf_pkg::TONES];
  logic [scf_pkg::STEP_W-1:0]             step_q [scf_pkg::TONES];
  logic [scf_pkg::IN_W-1:0]               tick_q;
  logic [31:0]                            phase_q [scf_pkg::TONES];
  logic [31:0]                            phase_d [scf_pkg::TONES];
  logic [scf_pkg::PH_CNT_W-1:0]           dig_q;
  logic [scf_pkg::TONE_W-1:0]             k_q;
  logic signed [scf_pkg::PROD_W-1:0]      prod_q, prod_d, prod_rnd;
  logic [scf_pkg::OUT_W-1:0]              sum_q, out_q;
  logic                                   out_valid_q;
  logic                                   start;
  logic                                   in_acc, out_load, more_tones;
  scf_pkg::cos_res_t                      cres;

  assign n_eff = (tone_cnt_q > scf_pkg::CNT_W'(scf_pkg::TONES)) ?
                 scf_pkg::CNT_W'(scf_pkg::TONES) : tone_cnt_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_cnt_q <= '0;
      for (int k = 0; k < scf_pkg::TONES; k++) begin
        amp_q[k]  <= '0;
        step_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_addr_i == scf_pkg::REG_TONE_COUNT) begin
        tone_cnt_q <= cfg_wdata_i[scf_pkg::CNT_W-1:0];
      end
      for (int k = 0; k < scf_pkg::TONES; k++) begin
        if (cfg_addr_i == scf_pkg::REG_AMP_BASE + scf_pkg::CFG_ADDR_W'(k)) begin
          amp_q[k] <= cfg_wdata_i[scf_pkg::AMP_W-1:0];
        end
        if (cfg_addr_i == scf_pkg::REG_STEP_BASE + scf_pkg::CFG_ADDR_W'(k)) begin
          step_q[k] <= cfg_wdata_i[scf_pkg::STEP_W-1:0];
        end
      end
    end
  end

  // radix-4 phase multiply, all tones in parallel
  always_comb begin
    logic [1:0] dig;
    dig = tick_q[scf_pkg::IN_W-1 -: 2];
    for (int k = 0; k < scf_pkg::TONES; k++) begin
      phase_d[k] = {phase_q[k][29:0], 2'b00}
                 + (dig[0] ? step_q[k] : 32'd0)
                 + (dig[1] ? {step_q[k][30:0], 1'b0} : 32'd0);
    end
  end

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
  assign more_tones = ({1'b0, k_q} + 1'b1) < {1'b0, n_eff};
  assign start      = (state_q == ST_LAUNCH);
  assign prod_d     = amp_q[k_q] * cres.cosine;
  assign prod_rnd   = (prod_q + RND_HALF) >>> 15;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_PHASE;
      end
      ST_PHASE: begin
        if (dig_q == scf_pkg::PH_CNT_W'(scf_pkg::PH_DIGITS - 1)) begin
          state_d = (n_eff == '0) ? ST_DONE : ST_LAUNCH;
        end
      end
      ST_LAUNCH: state_d = ST_ROT;
      ST_ROT: begin
        if (cres.done) state_d = ST_ACC;
      end
      ST_ACC: state_d = more_tones ? ST_LAUNCH : ST_DONE;
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      dig_q       <= '0;
      k_q         <= '0;
      sum_q       <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        dig_q <= '0;
        k_q   <= '0;
        sum_q <= '0;
      end else begin
        if (state_q == ST_PHASE) dig_q <= dig_q + 1'b1;
        if (state_q == ST_ACC) begin
          sum_q <= sum_q + prod_rnd[scf_pkg::OUT_W-1:0];
          if (more_tones) k_q <= k_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tick_q <= s_axis_tdata;
      for (int k = 0; k < scf_pkg::TONES; k++) begin
        phase_q[k] <= '0;
      end
    end else if (state_q == ST_PHASE) begin
      tick_q <= {tick_q[scf_pkg::IN_W-3:0], 2'b00};
      for (int k = 0; k < scf_pkg::TONES; k++) begin
        phase_q[k] <= phase_d[k];
      end
    end
    if (state_q == ST_ROT && cres.done) begin
      prod_q <= prod_d;
    end
    if (out_load) begin
      out_q <= sum_q;
    end
  end

  scf_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .phase_i (phase_q[k_q]),
    .res_o   (cres)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(scf_pkg::TD_W - scf_pkg::OUT_W){1'b0}}, out_q};

endmodule

`default_nettype wire

### rtl/scf_cordic.sv
// Iterative CORDIC cosine: one rotation per cycle, quadrant fold, Q2.15 out.
// Depends on scf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scf_cordic (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [31:0]           phase_i,
  output scf_pkg::cos_res_t          res_o
);

  localparam logic signed [scf_pkg::XY_W-1:0] RND_HALF = 33'sd16384;
  localparam logic signed [scf_pkg::XY_W-1:0] Q15_MAX  = 33'sd32767;
  localparam logic signed [scf_pkg::XY_W-1:0] Q15_MIN  = -33'sd32768;

  logic                               busy_q, fin_q, done_q;
  logic signed [scf_pkg::XY_W-1:0]    x_q, y_q, x_d, y_d;
  logic signed [scf_pkg::Z_W-1:0]     z_q, z_d;
  logic [scf_pkg::ITER_W-1:0]         iter_q;
  logic [1:0]                         quad_q;
  logic signed [scf_pkg::COS_W-1:0]   cos_q, cos_d;
  logic signed [scf_pkg::XY_W-1:0]    xs, ys;
  logic signed [scf_pkg::Z_W-1:0]     ang;
  logic signed [scf_pkg::Q15_W-1:0]   xc, yc;
  logic                               last_iter;

  function automatic logic signed [scf_pkg::Q15_W-1:0] to_q15(
    input logic signed [scf_pkg::XY_W-1:0] v);
    logic signed [scf_pkg::XY_W-1:0] r;
    logic signed [scf_pkg::Q15_W-1:0] o;
    r = (v + RND_HALF) >>> 15;
    if (r > Q15_MAX) begin
      o = Q15_MAX[scf_pkg::Q15_W-1:0];
    end else if (r < Q15_MIN) begin
      o = Q15_MIN[scf_pkg::Q15_W-1:0];
    end else begin
      o = r[scf_pkg::Q15_W-1:0];
    end
    return o;
  endfunction

  assign last_iter = (iter_q == scf_pkg::ITER_W'(scf_pkg::CORDIC_ITERS - 1));

  always_comb begin
    xs  = x_q >>> iter_q;
    ys  = y_q >>> iter_q;
    ang = scf_pkg::atan_val(iter_q);
    if (!z_q[scf_pkg::Z_W-1]) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - ang;
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + ang;
    end
  end

  always_comb begin
    xc = to_q15(x_q);
    yc = to_q15(y_q);
    case (quad_q)
      2'd0:    cos_d = {xc[scf_pkg::Q15_W-1], xc};
      2'd1:    cos_d = -{yc[scf_pkg::Q15_W-1], yc};
      2'd2:    cos_d = -{xc[scf_pkg::Q15_W-1], xc};
      2'd3:    cos_d = {yc[scf_pkg::Q15_W-1], yc};
      default: cos_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      fin_q  <= busy_q && last_iter && !start_i;
      done_q <= fin_q;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + 1'b1;
        if (last_iter) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= scf_pkg::CORDIC_X0;
      y_q    <= '0;
      z_q    <= {2'b00, phase_i[29:0]};
      quad_q <= phase_i[31:30];
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
    if (fin_q) begin
      cos_q <= cos_d;
    end
  end

  assign res_o = '{done: done_q, cosine: cos_q};

endmodule

`default_nettype wire

### rtl/scf_checker.sv
// Port-level checker for the sum of cosines force unit, bound to the top.
// Depends on scf_pkg and sum_of_cosines_force_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "sum_of_cosines_force_unit_macros.svh"

module scf_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      s_axis_tvalid,
  input wire logic                      s_axis_tready,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [scf_pkg::TD_W-1:0]  m_axis_tdata
);

  `SCF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `SCF_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
  `SCF_ASSERT(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[scf_pkg::TD_W-1:scf_pkg::OUT_W] == '0)
  `SCF_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind sum_of_cosines_force_unit scf_checker u_scf_checker (.*);

`default_nettype wire
